@@ src/bpfr_pkg.sv @@
// Package for the buffer pool frame replacer: sizes, codes and shared structs.
// No dependencies.
package bpfr_pkg;
	localparam int NumFrames = 8;
	localparam int FrameBits = $clog2(NumFrames);
	localparam int StampBits = 32;
	localparam int PageBits  = 16;
	localparam int PinBits   = 8;

	localparam logic [1:0] FUNC_PIN     = 2'd0;
	localparam logic [1:0] FUNC_UNPIN   = 2'd1;
	localparam logic [1:0] FUNC_HOLD    = 2'd2;
	localparam logic [1:0] FUNC_RELEASE = 2'd3;

	localparam logic [1:0] POL_LRU   = 2'd0;
	localparam logic [1:0] POL_MRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_LOADED   = 3'd1;
	localparam logic [2:0] ST_EVICTED  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOT_RES  = 3'd4;
	localparam logic [2:0] ST_UNPINNED = 3'd5;
	localparam logic [2:0] ST_NOT_HELD = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch a new request
		logic scan_clr;  // reset scan pointer and search flags
		logic scan_step; // examine one frame for tag, free and victim
		logic sweep_clr; // start clock sweep at the hand
		logic sweep_step;// examine one frame at the sweep pointer
		logic commit;    // apply the operation and build the result
	} bpfr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;   // scan pointer at last frame
		logic hit;         // tag found
		logic is_pin;      // request is a pin
		logic free_found;  // a free frame exists
		logic any_elig;    // an eligible victim exists
		logic clock_pol;   // policy is clock sweep
		logic sweep_found; // sweep found its victim
	} bpfr_stat_t;
endpackage

@@ src/bpfr_ctrl.sv @@
// Controller state machine for the buffer pool frame replacer.
// Depends on bpfr_pkg.
module bpfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_busy,
	input  bpfr_pkg::bpfr_stat_t st,
	output bpfr_pkg::bpfr_cmd_t  cmd,
	output logic                idle
);
	import bpfr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SWEEP = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = !out_busy;
				if (in_fire) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// after the scan, or a sweep that found its victim, decide whether a sweep is needed or commit
				if (st.is_pin && !st.hit && !st.free_found && st.any_elig
						&& st.clock_pol && !st.sweep_found) begin
					cmd.sweep_clr = 1'b1;
					state_d = S_SWEEP;
				end else begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_found) begin
					state_d = S_COMMIT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// at most one command strobe of the scan family at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_step && cmd.sweep_step)) else $error("scan and sweep overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE) else $error("commit not followed by idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
endmodule

@@ src/bpfr_dp.sv @@
// Datapath for the buffer pool frame replacer: frame table, scan, sweep, result.
// Depends on bpfr_pkg.
module bpfr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpfr_pkg::bpfr_cmd_t            cmd,
	output bpfr_pkg::bpfr_stat_t           st,
	input  logic [1:0]                    func,
	input  logic [bpfr_pkg::PageBits-1:0] page_id,
	input  logic                          dirty_mark,
	input  logic [1:0]                    policy,
	output logic [2:0]                    res_status,
	output logic [2:0]                    res_frame,
	output logic                          res_wb,
	output logic [bpfr_pkg::PageBits-1:0] res_ev,
	output logic [bpfr_pkg::PinBits-1:0]  res_pins
);
	import bpfr_pkg::*;

	logic [PageBits-1:0]  tag_q   [NumFrames];
	logic [StampBits-1:0] stamp_q [NumFrames];
	logic [PinBits-1:0]   pins_q  [NumFrames];
	logic [NumFrames-1:0] valid_q, dirty_q, held_q, ref_q;
	logic [FrameBits-1:0] hand_q;
	logic [StampBits-1:0] stamp_ctr_q;

	logic [1:0]           func_q;
	logic [PageBits-1:0]  page_q;
	logic                 dmark_q;

	logic [FrameBits-1:0] ptr_q, swp_q;
	logic                 hit_q, free_q, best_ok_q, swp_ok_q;
	logic [FrameBits-1:0] hit_idx_q, free_idx_q, best_idx_q, swp_idx_q;
	logic [4:0]           swp_cnt_q;

	logic elig_p, elig_s;
	logic better;

	assign elig_p = valid_q[ptr_q] && pins_q[ptr_q] == '0 && !held_q[ptr_q];
	assign elig_s = valid_q[swp_q] && pins_q[swp_q] == '0 && !held_q[swp_q];
	assign better = (policy == POL_MRU) ? (stamp_q[ptr_q] > stamp_q[best_idx_q])
		: (stamp_q[ptr_q] < stamp_q[best_idx_q]);

	assign st.scan_last   = ptr_q == FrameBits'(NumFrames - 1);
	assign st.hit         = hit_q;
	assign st.is_pin      = func_q == FUNC_PIN;
	assign st.free_found  = free_q;
	assign st.any_elig    = best_ok_q;
	assign st.clock_pol   = policy == POL_CLOCK;
	assign st.sweep_found = swp_ok_q;

	// scan / sweep pointers and search flags bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; swp_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
			best_ok_q <= 1'b0; swp_ok_q <= 1'b0; swp_cnt_q <= '0;
		end else begin
			if (cmd.scan_clr) begin
				ptr_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
				best_ok_q <= 1'b0; swp_ok_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				ptr_q <= (ptr_q == FrameBits'(NumFrames - 1)) ? '0 : ptr_q + 1'b1;
				if (!hit_q && valid_q[ptr_q] && tag_q[ptr_q] == page_q) begin
					hit_q <= 1'b1;
				end
				if (!free_q && !valid_q[ptr_q]) begin
					free_q <= 1'b1;
				end
				if (elig_p && (!best_ok_q || better)) begin
					best_ok_q <= 1'b1;
				end
			end
			if (cmd.sweep_clr) begin
				swp_q <= hand_q; swp_cnt_q <= '0;
			end
			if (cmd.sweep_step && !swp_ok_q) begin
				swp_q <= (swp_q == FrameBits'(NumFrames - 1)) ? '0 : swp_q + 1'b1;
				swp_cnt_q <= swp_cnt_q + 1'b1;
				if (elig_s && !ref_q[swp_q]) begin
					swp_ok_q <= 1'b1;
				end
			end
		end
	end

	// request latch and payload registers of the search
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func; page_q <= page_id; dmark_q <= dirty_mark;
		end
		if (cmd.scan_step) begin
			if (!hit_q && valid_q[ptr_q] && tag_q[ptr_q] == page_q) hit_idx_q <= ptr_q;
			if (!free_q && !valid_q[ptr_q]) free_idx_q <= ptr_q;
			if (elig_p && (!best_ok_q || better)) best_idx_q <= ptr_q;
		end
		if (cmd.sweep_step && !swp_ok_q && elig_s && !ref_q[swp_q]) begin
			swp_idx_q <= swp_q;
		end
	end

	// commit: choose frame and apply the operation
	logic [FrameBits-1:0] vic;
	logic [FrameBits-1:0] fsel;
	logic                 fvalid;
	logic [2:0]           stat;
	always_comb begin
		vic = (policy == POL_CLOCK) ? swp_idx_q : best_idx_q;
		fsel = hit_idx_q;
		fvalid = hit_q;
		stat = ST_DONE;
		if (func_q == FUNC_PIN) begin
			if (hit_q) begin
				stat = ST_DONE;
			end else if (free_q) begin
				fsel = free_idx_q; fvalid = 1'b1; stat = ST_LOADED;
			end else if (best_ok_q) begin
				fsel = vic; fvalid = 1'b1; stat = ST_EVICTED;
			end else begin
				stat = ST_FULL;
			end
		end else if (!hit_q) begin
			stat = ST_NOT_RES;
		end else if (func_q == FUNC_UNPIN) begin
			stat = (pins_q[fsel] == '0) ? ST_UNPINNED : ST_DONE;
		end else if (func_q == FUNC_RELEASE) begin
			stat = held_q[fsel] ? ST_DONE : ST_NOT_HELD;
		end
	end

	logic [PinBits-1:0] new_pins;
	always_comb begin
		new_pins = pins_q[fsel];
		case (func_q)
			FUNC_PIN:   new_pins = hit_q ? ((pins_q[fsel] == '1) ? pins_q[fsel]
				: pins_q[fsel] + 1'b1) : PinBits'(1);
			FUNC_UNPIN: new_pins = (pins_q[fsel] == '0) ? '0 : pins_q[fsel] - 1'b1;
			default:    new_pins = pins_q[fsel];
		endcase
	end

	// frame table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; dirty_q <= '0; held_q <= '0; ref_q <= '0;
			hand_q <= '0; stamp_ctr_q <= '0;
			for (int i = 0; i < NumFrames; i++) pins_q[i] <= '0;
		end else begin
			// clock sweep clears reference bits of passed eligible frames
			if (cmd.sweep_step && !swp_ok_q && elig_s && ref_q[swp_q]) begin
				ref_q[swp_q] <= 1'b0;
			end
			if (cmd.commit && fvalid) begin
				pins_q[fsel] <= new_pins;
				if (func_q == FUNC_PIN) begin
					ref_q[fsel] <= 1'b1;
					stamp_ctr_q <= stamp_ctr_q + 1'b1;
					if (!hit_q) begin
						valid_q[fsel] <= 1'b1; dirty_q[fsel] <= 1'b0; held_q[fsel] <= 1'b0;
						if (stat == ST_EVICTED && policy == POL_CLOCK) begin
							hand_q <= (vic == FrameBits'(NumFrames - 1)) ? '0 : vic + 1'b1;
						end
					end
				end else if (func_q == FUNC_UNPIN) begin
					dirty_q[fsel] <= dmark_q;
				end else if (func_q == FUNC_HOLD) begin
					held_q[fsel] <= 1'b1;
				end else begin
					held_q[fsel] <= 1'b0;
				end
			end
		end
	end

	// tags, stamps and result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (fvalid && func_q == FUNC_PIN) begin
				stamp_q[fsel] <= stamp_ctr_q;
				if (!hit_q) tag_q[fsel] <= page_q;
			end
			res_status <= stat;
			res_frame  <= fvalid ? 3'(fsel) : 3'd0;
			res_pins   <= fvalid ? new_pins : '0;
			res_wb     <= (stat == ST_EVICTED) ? dirty_q[fsel] : 1'b0;
			res_ev     <= (stat == ST_EVICTED) ? tag_q[fsel] : '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> swp_cnt_q <= 5'(2 * NumFrames + 1)) else $error("sweep overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stat == ST_EVICTED) |-> valid_q[fsel]) else $error("evict invalid");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stat == ST_LOADED) |-> !valid_q[fsel]) else $error("load into used");
endmodule

@@ src/buffer_pool_frame_replacer.sv @@
// Buffer pool frame replacer top level: stream ports, APB register, output stage.
// Flow: an accepted input is checked against all 8 frames by a serial scan, then a commit
// state registers the result; under clock policy a sweep from the hand may come between.
// One item at a time: no new input is accepted until its result is committed, and a result
// waiting on m_tready holds off the next input.
// Reset: arst_n clears frame valid/pin/dirty/hold/ref bits, hand, stamp counter, policy.
// Depends on bpfr_pkg, bpfr_ctrl, bpfr_dp.
module buffer_pool_frame_replacer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // func[1:0], page_id[17:2], dirty_mark[18], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // status[2:0], frame_index[5:3], writeback[6],
	                              // evicted_page[22:7], pin_count_now[30:23], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bpfr_pkg::*;

	bpfr_cmd_t  cmd;
	bpfr_stat_t st;
	logic       idle, in_fire, out_q;
	logic [2:0] r_status, r_frame;
	logic       r_wb;
	logic [PageBits-1:0] r_ev;
	logic [PinBits-1:0]  r_pins;
	logic [1:0] policy_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {30'd0, policy_q} : 32'd0;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			policy_q <= pwdata[1:0];
		end
	end

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
		end else if (cmd.commit) begin
			out_q <= 1'b1;
		end else if (m_tready) begin
			out_q <= 1'b0;
		end
	end

	assign m_tvalid = out_q;
	assign m_tdata = {1'b0, r_pins, r_ev, r_wb, r_frame, r_status};

	bpfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_q && !m_tready),
		.st(st), .cmd(cmd), .idle(idle)
	);

	bpfr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.func(s_tdata[1:0]), .page_id(s_tdata[17:2]), .dirty_mark(s_tdata[18]),
		.policy(policy_q),
		.res_status(r_status), .res_frame(r_frame), .res_wb(r_wb),
		.res_ev(r_ev), .res_pins(r_pins)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_q && !m_tready)) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("second item accepted");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7) else $error("bad status");
endmodule
